// ===== rtl/kae_pkg.sv =====
package kae_pkg;

    localparam int KEY_MAX     = 16;
    localparam int CAPTURE_MAX = 35;

    // Key storage holds at most 16 characters
    localparam int KEY_LIM   = (KEY_MAX < 16) ? KEY_MAX : 16;
    localparam int WIN_DEPTH = (KEY_LIM > 1) ? KEY_LIM - 1 : 1;
    localparam int FILL_W    = $clog2(KEY_LIM + 1);
    localparam int SEL_W     = (KEY_LIM > 1) ? $clog2(KEY_LIM) : 1;
    localparam int CNT_W     = $clog2(CAPTURE_MAX + 1);
    localparam int KLEN_W    = 5;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;
    localparam logic [1:0] CFG_END_CHAR = 2'd3;

    localparam logic [2:0] ST_MORE      = 3'd0;
    localparam logic [2:0] ST_END_CHAR  = 3'd1;
    localparam logic [2:0] ST_LIMIT     = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [KEY_LIM*8-1:0] key_chars;
        logic [KLEN_W-1:0]    key_len;
        logic [7:0]           end_char;
    } cfg_t;

endpackage

// ===== rtl/keyed_attribute_extractor.sv =====
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in        in         in_valid/in_stall     data_byte, first_byte, last_byte
// out       out        out_valid/out_stall   value_byte, value_valid, end_status, value_last
//
// One byte per cycle sustained while out_stall is low. An item is held in the
// input register, then matched and loaded into the result register when that
// register advances, after which its result can be taken.
// cfg_ready is always high. rst_n clears the valid flags, phase, count and fill.
// While a held result is stalled, the input register cannot advance, whether
// or not its item gives a result; in_stall rises once that register is full.
module keyed_attribute_extractor
    import kae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  value_byte,
    output logic        value_valid,
    output logic [2:0]  end_status,
    output logic        value_last
);

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_CAPTURE = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    cfg_t cfg;

    logic             s1_valid_reg;
    logic [7:0]       s1_data_reg;
    logic             s1_first_reg;
    logic             s1_last_reg;
    logic             s1_adv;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic [1:0]       phase_eff;
    logic             searching;
    logic             hit;

    logic             res;
    logic [7:0]       res_byte;
    logic             res_valid;
    logic [2:0]       res_status;
    logic             res_last;

    logic             out_valid_reg;
    logic [7:0]       value_byte_reg;
    logic             value_valid_reg;
    logic [2:0]       end_status_reg;
    logic             value_last_reg;

    kae_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign phase_eff = s1_first_reg ? PH_SEARCH : phase_reg;
    assign searching = (phase_eff == PH_SEARCH);

    kae_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_adv && searching),
        .first (s1_first_reg),
        .data  (s1_data_reg),
        .cfg   (cfg),
        .hit   (hit)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
    end

    assign count_inc = s1_first_reg ? CNT_W'(1) : count_reg + CNT_W'(1);

    always_comb
    begin
        phase_next = phase_eff;
        count_next = s1_first_reg ? '0 : count_reg;
        res        = 1'b0;
        res_byte   = '0;
        res_valid  = 1'b0;
        res_status = ST_MORE;
        res_last   = 1'b0;
        unique case (phase_eff)
            PH_SEARCH:
            begin
                if (hit)
                begin
                    count_next = '0;
                    if (s1_last_reg)
                    begin
                        phase_next = PH_DONE;
                        res        = 1'b1;
                        res_status = ST_TRUNC;
                        res_last   = 1'b1;
                    end
                    else
                        phase_next = PH_CAPTURE;
                end
                else if (s1_last_reg)
                begin
                    phase_next = PH_DONE;
                    res        = 1'b1;
                    res_status = ST_NOT_FOUND;
                    res_last   = 1'b1;
                end
            end
            PH_CAPTURE:
            begin
                res = 1'b1;
                priority if (s1_data_reg == cfg.end_char)
                begin
                    phase_next = PH_DONE;
                    res_status = ST_END_CHAR;
                    res_last   = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                    res_byte   = s1_data_reg;
                    res_valid  = 1'b1;
                    if (count_inc >= CNT_W'(CAPTURE_MAX))
                    begin
                        phase_next = PH_DONE;
                        res_status = ST_LIMIT;
                        res_last   = 1'b1;
                    end
                    else if (s1_last_reg)
                    begin
                        phase_next = PH_DONE;
                        res_status = ST_TRUNC;
                        res_last   = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = phase_eff;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            count_reg <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Hold the result until taken; load a new one only on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && res)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res)
        begin
            value_byte_reg  <= res_byte;
            value_valid_reg <= res_valid;
            end_status_reg  <= res_status;
            value_last_reg  <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_byte  = value_byte_reg;
    assign value_valid = value_valid_reg;
    assign end_status  = end_status_reg;
    assign value_last  = value_last_reg;

endmodule

// ===== rtl/kae_cfg_regs.sv =====
module kae_cfg_regs
    import kae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output cfg_t        cfg
);

    logic [63:0]       key_low_reg;
    logic [63:0]       key_high_reg;
    logic [KLEN_W-1:0] key_len_reg;
    logic [7:0]        end_char_reg;
    logic [127:0]      key_all;
    logic [KLEN_W-1:0] key_len_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KLEN_W'(1);
            end_char_reg <= 8'd34;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[KLEN_W-1:0];
                CFG_END_CHAR: end_char_reg <= cfg_data[7:0];
            endcase
        end
    end

    assign key_all       = {key_high_reg, key_low_reg};
    assign cfg.key_chars = key_all[KEY_LIM*8-1:0];
    assign cfg.end_char  = end_char_reg;
    assign cfg.key_len   = key_len_eff;

    // Clamp key length to 1..KEY_LIM
    always_comb
    begin
        priority if (key_len_reg == '0)
            key_len_eff = KLEN_W'(1);
        else if (key_len_reg > KLEN_W'(KEY_LIM))
            key_len_eff = KLEN_W'(KEY_LIM);
        else
            key_len_eff = key_len_reg;
    end

endmodule

// ===== rtl/kae_window.sv =====
module kae_window
    import kae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic       first,
    input  logic [7:0] data,
    input  cfg_t       cfg,
    output logic       hit
);

    logic [7:0]        recent_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_eff;
    logic [7:0]        win [KEY_LIM];
    logic [KEY_LIM-1:0] len_match;
    logic [SEL_W-1:0]  len_sel;
    logic              fill_ok;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            recent_reg[0] <= data;
            for (int j = 1; j < WIN_DEPTH; j++)
                recent_reg[j] <= recent_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (shift)
        begin
            if (first)
                fill_reg <= FILL_W'(1);
            else if (fill_reg < FILL_W'(KEY_LIM))
                fill_reg <= fill_reg + FILL_W'(1);
        end
    end

    // A new payload sees an empty window
    assign fill_eff = first ? '0 : fill_reg;

    always_comb
    begin
        win[0] = data;
        for (int j = 1; j < KEY_LIM; j++)
            win[j] = recent_reg[j-1];
    end

    // One compare per candidate key length; the key ends at the newest byte
    always_comb
    begin
        for (int k = 1; k <= KEY_LIM; k++)
        begin
            len_match[k-1] = 1'b1;
            for (int i = 0; i < k; i++)
            begin
                if (win[k-1-i] != cfg.key_chars[8*i +: 8])
                    len_match[k-1] = 1'b0;
            end
        end
    end

    assign len_sel = SEL_W'(cfg.key_len - KLEN_W'(1));
    assign fill_ok = ({1'b0, fill_eff} + (FILL_W+1)'(1)) >= (FILL_W+1)'(cfg.key_len);
    assign hit     = fill_ok && len_match[len_sel];

endmodule
